// ===== rtl/core/ssd_pkg.sv =====
package ssd_pkg;

   localparam int DIGIT_COUNT = 4;
   localparam int SCAN_WIDTH  = 2;
   localparam int VALUE_WIDTH = 14;

   localparam logic [VALUE_WIDTH-1:0] MAX_SHOWN = 14'd9999;

   // floor(v * RECIP >> SHIFT) equals the quotient over the operand's range (0..9999, 0..999, 0..99)
   localparam logic [13:0] RECIP_1000 = 14'd8389;
   localparam int          SHIFT_1000 = 23;
   localparam logic [5:0]  RECIP_100  = 6'd41;
   localparam int          SHIFT_100  = 12;
   localparam logic [7:0]  RECIP_10   = 8'd205;
   localparam int          SHIFT_10   = 11;

   localparam logic [7:0] SEG_DOT   = 8'h80;
   localparam logic [7:0] SEG_BLANK = 8'h00;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef struct packed {
      logic       blank;
      logic [3:0] value;
   } digit_type;

   typedef struct packed {
      op_type                            op;
      digit_type [DIGIT_COUNT-1:0]       digits;   // index 0 = thousands
   } item_type;

   function automatic logic [13:0] times_1000(input logic [3:0] d);
      logic [13:0] r;
      unique case (d)
         4'd1:    r = 14'd1000;
         4'd2:    r = 14'd2000;
         4'd3:    r = 14'd3000;
         4'd4:    r = 14'd4000;
         4'd5:    r = 14'd5000;
         4'd6:    r = 14'd6000;
         4'd7:    r = 14'd7000;
         4'd8:    r = 14'd8000;
         4'd9:    r = 14'd9000;
         default: r = 14'd0;
      endcase
      return r;
   endfunction

   function automatic logic [9:0] times_100(input logic [3:0] d);
      logic [9:0] r;
      unique case (d)
         4'd1:    r = 10'd100;
         4'd2:    r = 10'd200;
         4'd3:    r = 10'd300;
         4'd4:    r = 10'd400;
         4'd5:    r = 10'd500;
         4'd6:    r = 10'd600;
         4'd7:    r = 10'd700;
         4'd8:    r = 10'd800;
         4'd9:    r = 10'd900;
         default: r = 10'd0;
      endcase
      return r;
   endfunction

   function automatic logic [6:0] times_10(input logic [3:0] d);
      logic [6:0] r;
      unique case (d)
         4'd1:    r = 7'd10;
         4'd2:    r = 7'd20;
         4'd3:    r = 7'd30;
         4'd4:    r = 7'd40;
         4'd5:    r = 7'd50;
         4'd6:    r = 7'd60;
         4'd7:    r = 7'd70;
         4'd8:    r = 7'd80;
         4'd9:    r = 7'd90;
         default: r = 7'd0;
      endcase
      return r;
   endfunction

   // common-cathode pattern, bit0 = a .. bit6 = g
   function automatic logic [7:0] seg_code(input logic [3:0] d);
      logic [7:0] r;
      unique case (d)
         4'd0:    r = 8'h3F;
         4'd1:    r = 8'h06;
         4'd2:    r = 8'h5B;
         4'd3:    r = 8'h4F;
         4'd4:    r = 8'h66;
         4'd5:    r = 8'h6D;
         4'd6:    r = 8'h7D;
         4'd7:    r = 8'h07;
         4'd8:    r = 8'h7F;
         4'd9:    r = 8'h6F;
         default: r = SEG_BLANK;
      endcase
      return r & ~SEG_DOT;
   endfunction

endpackage

// ===== rtl/core/seven_segment_scan_driver_unit.sv =====
// Four-digit multiplexed seven-segment scan driver, common cathode.
// Input beats (req_): tuser selects the kind. A load beat (tuser = 0) carries a
// binary number in tdata; it is clamped to 9999, split into decimal digits
// with leading-zero blanking and stored, and it yields no result beat. A tick
// beat (tuser = 1) yields one result beat (rsp_) with the segment byte of the
// current digit and its position (0 = thousands), then advances the scan.
// Path: after a tick is accepted, the digit split runs in a three-stage front
// pipeline, a short queue follows, and the back end holds the digit buffer,
// scan index and the output register that presents the result beat.
// Throughput: one beat per cycle on the input while req_tready is high, loads and ticks mixed freely.
// When rsp_tready is low the held result stays, the queue and front pipeline
// fill, and req_tready drops after a few beats; nothing is lost or reordered.
// Reset: all digits show zero, nothing blanked, scan index at the thousands.
module seven_segment_scan_driver_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] number
   input  logic        req_tuser,   // [0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [7:0] segments, [9:8] digit_select, rest zero
);
   import ssd_pkg::*;

   logic                  fq_valid, fq_ready, qb_valid, qb_ready;
   item_type              fq_item, qb_item;
   logic [7:0]            segments;
   logic [SCAN_WIDTH-1:0] digit_select;

   ssd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_op     (op_type'(req_tuser)),
      .in_number (req_tdata),
      .out_valid (fq_valid),
      .out_ready (fq_ready),
      .out_item  (fq_item)
   );

   ssd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_item  (fq_item),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_item   (qb_item)
   );

   ssd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (qb_valid),
      .in_ready     (qb_ready),
      .in_item      (qb_item),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_segments (segments),
      .out_select   (digit_select)
   );

   assign rsp_tdata = {6'd0, digit_select, segments};

endmodule

// ===== rtl/core/ssd_front.sv =====
module ssd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  ssd_pkg::op_type   in_op,
   input  logic [15:0]       in_number,
   output logic              out_valid,
   input  logic              out_ready,
   output ssd_pkg::item_type out_item
);
   import ssd_pkg::*;

   // stage 1: saturate, thousands digit
   logic                   s1_valid_ff, s1_valid_in;
   op_type                 s1_op_ff;
   logic [VALUE_WIDTH-1:0] s1_value_ff, s1_value_in;
   logic [3:0]             s1_d0_ff, s1_d0_in;
   // stage 2: hundreds digit
   logic                   s2_valid_ff;
   op_type                 s2_op_ff;
   logic [3:0]             s2_d0_ff, s2_d1_in, s2_d1_ff;
   logic [9:0]             s2_rem_ff, s2_rem_in;
   // stage 3: tens, ones, blanking
   logic                   s3_valid_ff;
   item_type               s3_item_ff, s3_item_in;

   logic        s1_ready, s2_ready, s3_ready;
   logic [27:0] prod_1000;
   logic [15:0] prod_100;
   logic [14:0] prod_10;
   logic [6:0]  rem_10;
   logic [3:0]  d2, d3;

   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;
   assign s1_valid_in = in_valid;

   always_comb begin
      s1_value_in = (in_number > 16'(MAX_SHOWN)) ? MAX_SHOWN : in_number[VALUE_WIDTH-1:0];
      prod_1000   = 28'(s1_value_in) * 28'(RECIP_1000);
      s1_d0_in    = prod_1000[SHIFT_1000 +: 4];
   end

   always_comb begin
      s2_rem_in = 10'(s1_value_ff - times_1000(s1_d0_ff));
      prod_100  = 16'(s2_rem_in) * 16'(RECIP_100);
      s2_d1_in  = prod_100[SHIFT_100 +: 4];
   end

   always_comb begin
      rem_10  = 7'(s2_rem_ff - times_100(s2_d1_ff));
      prod_10 = 15'(rem_10) * 15'(RECIP_10);
      d2      = prod_10[SHIFT_10 +: 4];
      d3      = 4'(rem_10 - times_10(d2));
      s3_item_in.op              = s2_op_ff;
      s3_item_in.digits[0].value = s2_d0_ff;
      s3_item_in.digits[1].value = s2_d1_ff;
      s3_item_in.digits[2].value = d2;
      s3_item_in.digits[3].value = d3;
      s3_item_in.digits[0].blank = (s2_d0_ff == 4'd0);
      s3_item_in.digits[1].blank = s3_item_in.digits[0].blank && (s2_d1_ff == 4'd0);
      s3_item_in.digits[2].blank = s3_item_in.digits[1].blank && (d2 == 4'd0);
      s3_item_in.digits[3].blank = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= s1_valid_in;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && s1_valid_in) begin
         s1_op_ff    <= in_op;
         s1_value_ff <= s1_value_in;
         s1_d0_ff    <= s1_d0_in;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_op_ff  <= s1_op_ff;
         s2_d0_ff  <= s1_d0_ff;
         s2_d1_ff  <= s2_d1_in;
         s2_rem_ff <= s2_rem_in;
      end
      if (s3_ready && s2_valid_ff) begin
         s3_item_ff <= s3_item_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_item  = s3_item_ff;

endmodule

// ===== rtl/core/ssd_queue.sv =====
module ssd_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  ssd_pkg::item_type push_item,
   output logic              pop_valid,
   input  logic              pop_ready,
   output ssd_pkg::item_type pop_item
);
   import ssd_pkg::*;

   localparam int PTR_WIDTH   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   item_type               entry_ff [DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   push, pop;

   assign push_ready = (count_ff != COUNT_WIDTH'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_item;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_WIDTH'(DEPTH))
      else $error("queue count beyond depth");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue count did not drop on pop");

endmodule

// ===== rtl/core/ssd_back.sv =====
module ssd_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  ssd_pkg::item_type                 in_item,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [7:0]                        out_segments,
   output logic [ssd_pkg::SCAN_WIDTH-1:0]    out_select
);
   import ssd_pkg::*;

   digit_type [DIGIT_COUNT-1:0] buffer_ff, buffer_in;
   logic [SCAN_WIDTH-1:0]       scan_ff, scan_in;
   logic                        valid_ff, valid_in;
   logic [7:0]                  seg_ff, seg_in;
   logic [SCAN_WIDTH-1:0]       sel_ff;
   logic                        out_free, do_tick, do_load;
   digit_type                   cur;

   assign out_free = !valid_ff || out_ready;
   assign in_ready = (in_item.op == OP_LOAD) || out_free;
   assign do_load  = in_valid && (in_item.op == OP_LOAD);
   assign do_tick  = in_valid && (in_item.op == OP_TICK) && out_free;

   always_comb begin
      cur       = buffer_ff[scan_ff];
      seg_in    = cur.blank ? SEG_BLANK : seg_code(cur.value);
      buffer_in = do_load ? in_item.digits : buffer_ff;
      scan_in   = do_tick ? scan_ff + 1'b1 : scan_ff;
      valid_in  = do_tick ? 1'b1 : (out_ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_ff <= '0;
         scan_ff   <= '0;
         valid_ff  <= 1'b0;
      end else begin
         buffer_ff <= buffer_in;
         scan_ff   <= scan_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_tick) begin
         seg_ff <= seg_in;
         sel_ff <= scan_ff;
      end
   end

   assign out_valid    = valid_ff;
   assign out_segments = seg_ff;
   assign out_select   = sel_ff;

   a_tick_advances: assert property (@(posedge clock) disable iff (reset)
      do_tick |=> (scan_ff == $past(scan_ff) + 1'b1))
      else $error("scan index did not advance on tick");

   a_load_holds_scan: assert property (@(posedge clock) disable iff (reset)
      (do_load && !do_tick) |=> $stable(scan_ff))
      else $error("scan index moved on load");

endmodule

// ===== bench/tb_seven_segment_scan_driver_unit.sv =====
module tb_seven_segment_scan_driver_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import ssd_pkg::*;

   localparam int HOLD_CYCLES  = 80;
   localparam int STALL_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 12;
   localparam logic [15:0] SHOWN_LIMIT = 16'd9999;

   // common-cathode patterns for 0..9, a in bit 0
   localparam logic [7:0] DIGIT_PATTERN [10] = '{
      8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
   };

   typedef struct {
      logic [7:0] segments;
      logic [1:0] position;
   } lit_digit_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // [15:0] number
   logic        req_tuser  = 1'b0; // [0] operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // [7:0] segments, [9:8] digit_select, [15:10] zero

   // shadow of the display state
   digit_type     shadow_digits [DIGIT_COUNT];
   logic [1:0]    shadow_scan;
   lit_digit_type pending_digits [$];

   int sender_idle_pct   = 0;
   int receiver_idle_pct = 0;
   int holds_requested   = 0;
   int holds_served      = 0;
   int stall_left        = 0;
   int quiet_cycles      = 0;
   int mismatch_count    = 0;
   int loads_sent        = 0;
   int ticks_sent        = 0;
   int digits_checked    = 0;
   int blank_digits_seen = 0;
   int clamped_loads     = 0;

   seven_segment_scan_driver_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatch_count++;
   endtask

   function automatic void clear_display();
      for (int i = 0; i < DIGIT_COUNT; i++) shadow_digits[i] = '{blank: 1'b0, value: 4'd0};
      shadow_scan = '0;
   endfunction

   // update the shadow state for one accepted beat, queue the digit a tick shows
   function automatic void apply_beat(input op_type op, input logic [15:0] number);
      logic [15:0]   shown;
      logic [3:0]    thousands, hundreds, tens, ones;
      digit_type     entry;
      lit_digit_type lit;
      if (op == OP_LOAD) begin
         shown = (number > SHOWN_LIMIT) ? SHOWN_LIMIT : number;
         if (number > SHOWN_LIMIT) clamped_loads++;
         thousands = 4'(shown / 1000);
         hundreds  = 4'((shown / 100) % 10);
         tens      = 4'((shown / 10) % 10);
         ones      = 4'(shown % 10);
         shadow_digits[0] = '{blank: thousands == 0, value: thousands};
         shadow_digits[1] = '{blank: thousands == 0 && hundreds == 0, value: hundreds};
         shadow_digits[2] = '{blank: thousands == 0 && hundreds == 0 && tens == 0,
                              value: tens};
         shadow_digits[3] = '{blank: 1'b0, value: ones};
      end else begin
         entry = shadow_digits[shadow_scan];
         lit.segments = entry.blank ? 8'h00 : DIGIT_PATTERN[entry.value];
         lit.position = shadow_scan;
         if (entry.blank) blank_digits_seen++;
         pending_digits.push_back(lit);
         shadow_scan = shadow_scan + 2'd1;
      end
   endfunction

   task automatic send_beat(input op_type op, input logic [15:0] number);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= number;
      do @(posedge clock); while (!req_tready);
      apply_beat(op, number);
      if (op == OP_LOAD) loads_sent++;
      else ticks_sent++;
   endtask

   // spread values over every digit count, plus the clamped range
   function automatic logic [15:0] pick_number();
      case ($urandom_range(0, 5))
         0:       return 16'($urandom_range(0, 9));
         1:       return 16'($urandom_range(10, 99));
         2:       return 16'($urandom_range(100, 999));
         3:       return 16'($urandom_range(1000, 9999));
         4:       return 16'($urandom_range(10000, 65535));
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic send_ticks(input int count);
      for (int i = 0; i < count; i++) send_beat(OP_TICK, 16'($urandom_range(0, 65535)));
   endtask

   task automatic test_reset_display();
      // fresh buffer shows 0000, nothing blanked
      send_ticks(4);
   endtask

   task automatic test_directed_loads();
      send_beat(OP_LOAD, 16'hFFFF);
      send_beat(OP_TICK, 16'hFFFF);
      send_ticks(3);
      send_beat(OP_LOAD, 16'h0000);
      send_beat(OP_TICK, 16'h0000);
      send_beat(OP_TICK, 16'hFFFF);
      send_ticks(2);
      // loads between ticks, some mid-scan: position must not move
      send_beat(OP_LOAD, 16'd10);
      send_ticks(2);
      send_beat(OP_LOAD, 16'd100);
      send_ticks(2);
      send_beat(OP_LOAD, 16'd10000);
      send_ticks(2);
      send_beat(OP_LOAD, 16'd1000);
      send_ticks(2);
   endtask

   task automatic test_random_scans(input int item_count);
      int sent;
      int ticks;
      sent = 0;
      while (sent < item_count) begin
         if ($urandom_range(0, 3) != 0) begin
            ticks = $urandom_range(1, 8);
            send_beat(OP_LOAD, pick_number());
            send_ticks(ticks);
            sent += ticks + 1;
         end else begin
            send_beat($urandom_range(0, 1) ? OP_TICK : OP_LOAD, 16'($urandom_range(0, 65535)));
            sent++;
         end
      end
   endtask

   task automatic test_backpressure();
      int saved_idle;
      saved_idle = sender_idle_pct;
      sender_idle_pct = 0;
      holds_requested++;
      send_beat(OP_LOAD, pick_number());
      send_ticks(30);
      sender_idle_pct = saved_idle;
   endtask

   // receiver: random stalls, or one long hold when a test asks for it
   always @(posedge clock) begin
      if (holds_served != holds_requested) begin
         holds_served = holds_requested;
         stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
   end

   always @(posedge clock) begin : check_digits
      lit_digit_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_digits.size() == 0) begin
            report_mismatch($sformatf("result beat %h with nothing expected", rsp_tdata));
         end else begin
            want = pending_digits.pop_front();
            digits_checked++;
            if (rsp_tdata[7:0] !== want.segments)
               report_mismatch($sformatf("segments %h, want %h at position %0d",
                                         rsp_tdata[7:0], want.segments, want.position));
            if (rsp_tdata[9:8] !== want.position)
               report_mismatch($sformatf("digit_select %0d, want %0d",
                                         rsp_tdata[9:8], want.position));
            if (rsp_tdata[15:10] !== '0)
               report_mismatch($sformatf("pad bits %h not zero", rsp_tdata[15:10]));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("stalled for %0d cycles with %0d digits outstanding",
                     quiet_cycles, pending_digits.size());
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      clear_display();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_reset_display();
      test_directed_loads();

      sender_idle_pct   = 37;
      receiver_idle_pct = 45;
      test_random_scans(400);
      test_backpressure();

      sender_idle_pct   = 45;
      receiver_idle_pct = 37;
      test_random_scans(400);

      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      test_random_scans(400);

      req_tvalid <= 1'b0;
      while (pending_digits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d loads (%0d clamped) and %0d scan ticks under mixed stalls",
               loads_sent, clamped_loads, ticks_sent);
      $display("checked %0d digits, %0d of them blanked", digits_checked, blank_digits_seen);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
